### hdl/sfi_pkg.sv
// Package for the substring first-index search unit.
// Holds field widths, parameter defaults and configuration register indexes.
// Depends on nothing; imported by substring_first_index_unit.
package sfi_pkg;

   // Parameter defaults and fixed field widths.
   localparam int NEEDLE_MAX_DEFAULT    = 32;
   localparam int POSITION_BITS_DEFAULT = 32;
   localparam int BYTE_WIDTH            = 8;
   localparam int POSITION_WIDTH        = 32;
   localparam int LENGTH_WIDTH          = 6;
   localparam int CSR_DATA_WIDTH        = 64;
   localparam int CSR_INDEX_WIDTH       = 3;
   localparam int NEEDLE_WORDS          = 4;
   localparam int WORD_BYTES            = CSR_DATA_WIDTH / BYTE_WIDTH;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_NEEDLE_LOW    = 3'd0,
      CSR_NEEDLE_ONE    = 3'd1,
      CSR_NEEDLE_TWO    = 3'd2,
      CSR_NEEDLE_HIGH   = 3'd3,
      CSR_NEEDLE_LENGTH = 3'd4
   } csr_index_type;

endpackage

### hdl/substring_first_index_unit.sv
// Top level of the substring first-index search unit.
// Streams haystack bytes through a window and reports the first needle match.
// Depends on sfi_pkg for widths, defaults and register indexes.

// The unit takes one haystack byte per cycle unless input is held off as
// described below. Each accepted byte is shifted into a window register of
// the NEEDLE_MAX newest bytes; in the following cycle the window is
// compared in parallel against the needle, and for a byte marked last the
// result enters the output register when the compare stage advances. Input is
// held off only while a last byte waits in the compare stage and the output
// register still holds an untaken result. An empty needle reports found with
// position 0; the position counter saturates at its all-ones value.
// Configuration registers are written through the csr port, which is always
// ready; writes to indexes beyond needle_length are ignored.
module substring_first_index_unit
   import sfi_pkg::*;
#(
   parameter int NEEDLE_MAX    = NEEDLE_MAX_DEFAULT,
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // Haystack requests.
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [BYTE_WIDTH-1:0]      req_haystack_byte,
   input  logic                       req_last_byte,
   // Results.
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_found,
   output logic [POSITION_WIDTH-1:0]  rsp_position,
   // Configuration writes.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   localparam int WIN_IDX_BITS = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;

   // Configuration registers.
   logic [CSR_DATA_WIDTH-1:0] needle_word_ff [NEEDLE_WORDS];
   logic [LENGTH_WIDTH-1:0]   needle_len_ff;

   // Stream state: window of newest bytes (entry 0 newest), byte count, match.
   logic [BYTE_WIDTH-1:0]     window_ff [NEEDLE_MAX];
   logic [BYTE_WIDTH-1:0]     window_in [NEEDLE_MAX];
   logic [POSITION_BITS-1:0]  count_ff;
   logic [POSITION_BITS-1:0]  count_in;
   logic [POSITION_BITS-1:0]  count_base;
   logic                      match_seen_ff;
   logic                      match_seen_in;
   logic [POSITION_BITS-1:0]  match_start_ff;
   logic [POSITION_BITS-1:0]  match_start_in;

   // Compare stage: a byte whose window update has landed.
   logic                      cmp_valid_ff;
   logic                      cmp_last_ff;
   logic                      cmp_adv;
   logic                      cmp_done_last;

   // Output register.
   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic [POSITION_WIDTH-1:0] rsp_position_ff;
   logic                      out_free;

   logic                      req_accept;
   logic                      len_ok;
   logic                      window_hit;
   logic [NEEDLE_MAX-1:0]     lane_match;
   logic [POSITION_BITS-1:0]  new_start;
   logic                      result_found;
   logic [POSITION_BITS-1:0]  result_start;

   // Handshake control. A last byte in the compare stage needs a free output slot.
   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign cmp_adv       = cmp_valid_ff && (!cmp_last_ff || out_free);
   assign cmp_done_last = cmp_adv && cmp_last_ff;
   assign req_ready     = !cmp_valid_ff || cmp_adv;
   assign req_accept    = req_valid && req_ready;
   assign csr_ready     = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found     = rsp_found_ff;
   assign rsp_position  = rsp_position_ff;

   // Window compare: needle byte k lines up with window entry len-1-k.
   always_comb begin
      logic [LENGTH_WIDTH-1:0] idx_full;
      logic [WIN_IDX_BITS-1:0] idx;
      for (int k = 0; k < NEEDLE_MAX; k++) begin
         idx_full      = needle_len_ff - LENGTH_WIDTH'(1) - LENGTH_WIDTH'(k);
         idx           = idx_full[WIN_IDX_BITS-1:0];
         lane_match[k] = (LENGTH_WIDTH'(k) >= needle_len_ff) ||
                         (window_ff[idx] ==
                          needle_word_ff[k >> 3][(k & 7) * BYTE_WIDTH +: BYTE_WIDTH]);
      end
   end

   assign len_ok     = (needle_len_ff != '0) && (int'(needle_len_ff) <= NEEDLE_MAX) &&
                       (count_ff >= POSITION_BITS'(needle_len_ff));
   assign window_hit = len_ok && (&lane_match);
   assign new_start  = count_ff - POSITION_BITS'(needle_len_ff);

   // Result of the byte in the compare stage, including a match on that byte.
   assign result_found = (needle_len_ff == '0) || match_seen_ff || window_hit;
   always_comb begin
      if (needle_len_ff == '0) begin
         result_start = '0;
      end else if (match_seen_ff) begin
         result_start = match_start_ff;
      end else if (window_hit) begin
         result_start = new_start;
      end else begin
         result_start = '0;
      end
   end

   // Next stream state. The end of a haystack clears count and match.
   always_comb begin
      count_base = cmp_done_last ? '0 : count_ff;
      if (req_accept && (count_base != '1)) begin
         count_in = count_base + POSITION_BITS'(1);
      end else begin
         count_in = count_base;
      end

      window_in[0] = req_haystack_byte;
      for (int i = 1; i < NEEDLE_MAX; i++) begin
         window_in[i] = window_ff[i-1];
      end

      match_seen_in  = match_seen_ff;
      match_start_in = match_start_ff;
      if (cmp_done_last) begin
         match_seen_in  = 1'b0;
         match_start_in = '0;
      end else if (cmp_adv && !match_seen_ff && window_hit) begin
         match_seen_in  = 1'b1;
         match_start_in = new_start;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < NEEDLE_WORDS; w++) begin
            needle_word_ff[w] <= '0;
         end
         needle_len_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NEEDLE_LOW:    needle_word_ff[0] <= csr_data;
            CSR_NEEDLE_ONE:    needle_word_ff[1] <= csr_data;
            CSR_NEEDLE_TWO:    needle_word_ff[2] <= csr_data;
            CSR_NEEDLE_HIGH:   needle_word_ff[3] <= csr_data;
            CSR_NEEDLE_LENGTH: needle_len_ff     <= csr_data[LENGTH_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Window shift on each accepted request.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int i = 0; i < NEEDLE_MAX; i++) begin
            window_ff[i] <= window_in[i];
         end
      end
   end

   // Stream control state and the compare stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff       <= '0;
         match_seen_ff  <= 1'b0;
         match_start_ff <= '0;
         cmp_valid_ff   <= 1'b0;
         cmp_last_ff    <= 1'b0;
      end else begin
         count_ff       <= count_in;
         match_seen_ff  <= match_seen_in;
         match_start_ff <= match_start_in;
         if (req_accept) begin
            cmp_valid_ff <= 1'b1;
            cmp_last_ff  <= req_last_byte;
         end else if (cmp_adv) begin
            cmp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmp_done_last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmp_done_last) begin
         rsp_found_ff    <= result_found;
         rsp_position_ff <= POSITION_WIDTH'(result_start);
      end
   end

`ifndef SYNTH
   // A new result is loaded only from a last byte leaving the compare stage.
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_ready)) |->
         $past(cmp_valid_ff && cmp_last_ff))
      else $error("result loaded without a last byte in the compare stage");

   // A last byte blocked by a full output register holds off new requests.
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (cmp_valid_ff && cmp_last_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request accepted while the compare stage is stalled");

   // After the end of a haystack the byte count restarts.
   a_count_restart: assert property (@(posedge clock) disable iff (reset)
      cmp_done_last |=> (count_ff <= POSITION_BITS'(1)) && !match_seen_ff)
      else $error("stream state not cleared after the last byte");

   // A result without a match reports position zero.
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_position_ff == '0))
      else $error("no-match result carries a nonzero position");
`endif

endmodule
